// ----- hdl/emc_pkg.sv -----
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types, codes and the CRC-8 byte step of the end-to-end message check.
// ----------------------------------------------------------------------------
package emc_pkg;

    localparam logic [7:0] CRC_POLY    = 8'h2F;
    localparam logic [7:0] CRC_INIT    = 8'hFF;
    localparam logic [7:0] CRC_XOR_OUT = 8'hFF;
    localparam int         CFG_W       = 16;
    localparam int         CFG_IDX_W   = 3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SOME_LOST = 3'd1,
        ST_REPEATED  = 3'd2,
        ST_WRONG_SEQ = 3'd3,
        ST_WRONG_CRC = 3'd4,
        ST_INITIAL   = 3'd5,
        ST_SYNC      = 3'd6,
        ST_BAD_PATH  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        RX_VALID   = 2'd0,
        RX_INVALID = 2'd1,
        RX_INIT    = 2'd2,
        RX_NO_DATA = 2'd3
    } rx_state_t;

    typedef enum logic [2:0] {
        CFG_DATA_LENGTH    = 3'd0,
        CFG_DATA_ID        = 3'd1,
        CFG_COUNTER_OFFSET = 3'd2,
        CFG_CRC_OFFSET     = 3'd3,
        CFG_MAX_DELTA      = 3'd4
    } cfg_idx_t;

    // framing view of the beat being processed
    typedef struct packed {
        logic       last;
        logic [1:0] path;
        logic       crc_ok;
        logic [7:0] counter;
    } frm_info_t;

    typedef struct packed {
        status_t   status;
        logic      path0_error;
        logic      path1_error;
        rx_state_t rx_state;
        logic      error_flag;
    } res_t;

    // one byte through the crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/emc_frame.sv -----
// ----------------------------------------------------------------------------
// emc_frame
// Message framing: byte position, running CRC, CRC and counter capture.
// ----------------------------------------------------------------------------
module emc_frame #(
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          msg_byte,
    input  logic [1:0]          path_sel,
    input  logic [8:0]          data_length,
    input  logic [15:0]         data_id,
    input  logic [7:0]          counter_offset,
    input  logic [7:0]          crc_offset,
    output emc_pkg::frm_info_t  info
);

    localparam int POS_W = (MAX_MESSAGE_BYTES > 2) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam int LEN_W = (POS_W + 1 > 9) ? POS_W + 1 : 9;
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       cap_crc_reg, cap_crc_next;
    logic [7:0]       cap_cnt_reg, cap_cnt_next;
    logic [1:0]       path_reg, path_next;

    logic [LEN_W-1:0] len_ext;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] pos_plus;
    logic             is_crc;
    logic             is_cnt;
    logic             last;
    logic [7:0]       calc;

    always_comb
    begin
        len_ext = LEN_W'(data_length);
        if (len_ext == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_ext > LEN_W'(MAX_MESSAGE_BYTES))
        begin
            eff_len = LEN_W'(MAX_MESSAGE_BYTES);
        end
        else
        begin
            eff_len = len_ext;
        end
        pos_plus = LEN_W'(pos_reg) + LEN_W'(1);
        last     = (pos_plus >= eff_len);

        is_crc = (CMP_W'(pos_reg) == CMP_W'(crc_offset));
        is_cnt = (CMP_W'(pos_reg) == CMP_W'(counter_offset));

        path_next    = (pos_reg == '0) ? path_sel : path_reg;
        cap_crc_next = is_crc ? msg_byte : cap_crc_reg;
        cap_cnt_next = is_cnt ? msg_byte : cap_cnt_reg;
        crc_next     = is_crc ? crc_reg : emc_pkg::crc8_byte(crc_reg, msg_byte);

        // fold in the data id, low byte first
        calc = emc_pkg::crc8_byte(crc_next, data_id[7:0]);
        calc = emc_pkg::crc8_byte(calc, data_id[15:8]) ^ emc_pkg::CRC_XOR_OUT;

        pos_next = pos_reg + POS_W'(1);

        info.last    = last;
        info.path    = path_next;
        info.crc_ok  = (calc == cap_crc_next);
        info.counter = cap_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            crc_reg     <= emc_pkg::CRC_INIT;
            cap_crc_reg <= '0;
            cap_cnt_reg <= '0;
            path_reg    <= '0;
        end
        else if (step)
        begin
            path_reg <= path_next;
            if (last)
            begin
                pos_reg     <= '0;
                crc_reg     <= emc_pkg::CRC_INIT;
                cap_crc_reg <= '0;
                cap_cnt_reg <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                crc_reg     <= crc_next;
                cap_crc_reg <= cap_crc_next;
                cap_cnt_reg <= cap_cnt_next;
            end
        end
    end

endmodule

// ----- hdl/emc_seq.sv -----
// ----------------------------------------------------------------------------
// emc_seq
// Counter sequence check, per-path error marks and result mapping.
// ----------------------------------------------------------------------------
module emc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  emc_pkg::frm_info_t info,
    input  logic [6:0]         max_delta,
    output emc_pkg::res_t      res
);

    logic [7:0] last_cnt_reg, last_cnt_next;
    logic       seen_reg, seen_next;
    logic       mark0_reg, mark0_next;
    logic       mark1_reg, mark1_next;

    logic [7:0]        delta;
    logic              set_mark;
    logic              clr_mark;
    emc_pkg::status_t  status;

    always_comb
    begin
        delta         = info.counter - last_cnt_reg;
        set_mark      = 1'b0;
        clr_mark      = 1'b0;
        last_cnt_next = last_cnt_reg;
        seen_next     = seen_reg;

        if (info.path[1])
        begin
            status = emc_pkg::ST_BAD_PATH;
        end
        else if (!info.crc_ok)
        begin
            status   = emc_pkg::ST_WRONG_CRC;
            set_mark = 1'b1;
        end
        else if (!seen_reg)
        begin
            status        = emc_pkg::ST_INITIAL;
            seen_next     = 1'b1;
            last_cnt_next = info.counter;
            clr_mark      = 1'b1;
        end
        else if (delta == 8'd0)
        begin
            status = emc_pkg::ST_REPEATED;
        end
        else if (delta[7])
        begin
            status = emc_pkg::ST_WRONG_SEQ;
        end
        else if (delta == 8'd1)
        begin
            status        = emc_pkg::ST_OK;
            last_cnt_next = info.counter;
            clr_mark      = 1'b1;
        end
        else if (delta <= {1'b0, max_delta})
        begin
            status        = emc_pkg::ST_SOME_LOST;
            last_cnt_next = info.counter;
        end
        else
        begin
            status        = emc_pkg::ST_SYNC;
            last_cnt_next = info.counter;
        end

        mark0_next = mark0_reg;
        mark1_next = mark1_reg;
        if (set_mark || clr_mark)
        begin
            if (info.path[0])
            begin
                mark1_next = set_mark;
            end
            else
            begin
                mark0_next = set_mark;
            end
        end

        res.status      = status;
        res.path0_error = mark0_next;
        res.path1_error = mark1_next;
        res.error_flag  = 1'b0;
        case (status)
            emc_pkg::ST_OK, emc_pkg::ST_SOME_LOST:
            begin
                res.rx_state = emc_pkg::RX_VALID;
            end
            emc_pkg::ST_REPEATED, emc_pkg::ST_WRONG_SEQ, emc_pkg::ST_WRONG_CRC:
            begin
                res.rx_state   = emc_pkg::RX_INVALID;
                res.error_flag = 1'b1;
            end
            emc_pkg::ST_SYNC:
            begin
                res.rx_state = emc_pkg::RX_INIT;
            end
            emc_pkg::ST_INITIAL:
            begin
                res.rx_state = emc_pkg::RX_NO_DATA;
            end
            default:
            begin
                res.rx_state = emc_pkg::RX_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cnt_reg <= '0;
            seen_reg     <= 1'b0;
            mark0_reg    <= 1'b0;
            mark1_reg    <= 1'b0;
        end
        else if (step && info.last)
        begin
            last_cnt_reg <= last_cnt_next;
            seen_reg     <= seen_next;
            mark0_reg    <= mark0_next;
            mark1_reg    <= mark1_next;
        end
    end

endmodule

// ----- hdl/e2e_message_check.sv -----
// ----------------------------------------------------------------------------
// e2e_message_check
// End-to-end check of received messages, one message byte per beat.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle on the input channel, unless a
// message's last byte is held back. A beat lands in an input register and is
// processed from there; the last byte of a message produces one result beat,
// held in an output register until it is taken.
// Bytes that do not end a message flow on even while a result is waiting;
// a new message's last byte waits only until the previous result is taken.
// The one-byte CRC-8 update of the running CRC sets the rate of one byte per
// cycle when not held. Configuration is written through a plain write port.
module e2e_message_check #(
    parameter int MAX_MESSAGE_BYTES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [emc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [emc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    msg_byte,
    input  logic [1:0]                    path_sel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    check_status,
    output logic                          path0_error,
    output logic                          path1_error,
    output logic [1:0]                    receiver_state,
    output logic                          error_flag
);

    logic [8:0]  data_length_reg;
    logic [15:0] data_id_reg;
    logic [7:0]  counter_offset_reg;
    logic [7:0]  crc_offset_reg;
    logic [6:0]  max_delta_reg;

    logic        in_full_reg, in_full_next;
    logic [7:0]  byte_reg;
    logic [1:0]  path_reg;
    logic        out_valid_reg, out_valid_next;
    emc_pkg::res_t res_reg;

    logic               advance;
    emc_pkg::frm_info_t info;
    emc_pkg::res_t      res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg    <= 9'd8;
            data_id_reg        <= 16'd0;
            counter_offset_reg <= 8'd1;
            crc_offset_reg     <= 8'd0;
            max_delta_reg      <= 7'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                emc_pkg::CFG_DATA_LENGTH:    data_length_reg    <= cfg_wdata[8:0];
                emc_pkg::CFG_DATA_ID:        data_id_reg        <= cfg_wdata[15:0];
                emc_pkg::CFG_COUNTER_OFFSET: counter_offset_reg <= cfg_wdata[7:0];
                emc_pkg::CFG_CRC_OFFSET:     crc_offset_reg     <= cfg_wdata[7:0];
                emc_pkg::CFG_MAX_DELTA:      max_delta_reg      <= cfg_wdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // a beat that ends a message needs room in the output register
    assign advance  = in_full_reg && (!info.last || !out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && in_ready)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && info.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= msg_byte;
            path_reg <= path_sel;
        end
        if (advance && info.last)
        begin
            res_reg <= res;
        end
    end

    emc_frame #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .msg_byte       (byte_reg),
        .path_sel       (path_reg),
        .data_length    (data_length_reg),
        .data_id        (data_id_reg),
        .counter_offset (counter_offset_reg),
        .crc_offset     (crc_offset_reg),
        .info           (info)
    );

    emc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .info      (info),
        .max_delta (max_delta_reg),
        .res       (res)
    );

    assign out_valid      = out_valid_reg;
    assign check_status   = res_reg.status;
    assign path0_error    = res_reg.path0_error;
    assign path1_error    = res_reg.path1_error;
    assign receiver_state = res_reg.rx_state;
    assign error_flag     = res_reg.error_flag;

`ifndef SYNTH
    // a result is only ever loaded by the last byte of a message
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && info.last))
        else $error("result raised without a last byte");

    // a held input beat is never dropped while it waits
    a_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !advance |=> in_full_reg)
        else $error("input beat lost");

    // an unread result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(advance && info.last))
        else $error("pending result overwritten");

    // error flag goes with the invalid receiver state
    a_err_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.error_flag |-> res_reg.rx_state == emc_pkg::RX_INVALID)
        else $error("error flag with wrong receiver state");
`endif

endmodule
